### sv/gbe_pkg.sv
// Package for the gap-buffer edit engine.
// Holds field widths, default sizes, the register map, command codes, character codes,
// the read select and the controller/datapath command and status structs. No dependencies.
`default_nettype none

package gbe_pkg;

    // field widths
    localparam int CMD_W  = 4;
    localparam int CHAR_W = 8;
    localparam int OFFS_W = 12;
    localparam int ROW_W  = 13;
    localparam int KCNT_W = 9;
    localparam int ROWS_W = 8;
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    // default sizes
    localparam int DEF_TEXT_DEPTH = 4096;
    localparam int DEF_KILL_DEPTH = 256;
    localparam logic [ROWS_W-1:0] DEF_WINDOW_ROWS = 8'd24;

    // register map
    localparam logic [APB_AW-1:0] ADDR_WINDOW_ROWS = 2'd0;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 4'd0;
    localparam logic [CMD_W-1:0] CMD_BKSP   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_LEFT   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_LSTART = 4'd4;
    localparam logic [CMD_W-1:0] CMD_LEND   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_UP     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_KILL   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_YANK   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_READ   = 4'd10;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NL   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR   = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LOW  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_HIGH = 8'd126;

    // text store read address select
    typedef enum logic [1:0] {
        RS_GS_M1 = 2'd0,
        RS_GE    = 2'd1,
        RS_SCAN  = 2'd2,
        RS_OFFS  = 2'd3
    } t_rsel;

    // controller to datapath commands
    typedef struct packed {
        logic  load_in;
        logic  rd_en;
        t_rsel rsel;
        logic  step_back;
        logic  step_fwd;
        logic  del_back;
        logic  del_fwd;
        logic  put;
        logic  put_src;
        logic  kill_wr;
        logic  kill_rd;
        logic  k_clr;
        logic  k_inc;
        logic  klen_load;
        logic  col_clr;
        logic  col_inc;
        logic  col_dec;
        logic  line_inc;
        logic  line_dec;
        logic  track_dn;
        logic  track_up;
        logic  tgt_load;
        logic  tgt_dec;
        logic  scan_load;
        logic  scan_dec;
        logic  res_clr;
        logic  rd_setup;
        logic  char_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic gs_zero;
        logic ge_end;
        logic full;
        logic rd_nl;
        logic krd_nl;
        logic scan_zero;
        logic line_zero;
        logic col_zero;
        logic tgt_zero;
        logic yk_done;
        logic in_ok;
        logic in_nl;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/gbe_dp.sv
// Datapath of the gap-buffer edit engine: text and kill memories,
// gap pointers, cursor, view and kill counters. Uses gbe_pkg.
`default_nettype none

module gbe_dp
    import gbe_pkg::*;
#(
    parameter int TEXT_DEPTH = DEF_TEXT_DEPTH,
    parameter int KILL_DEPTH = DEF_KILL_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [CHAR_W-1:0] i_char_in,
    input  wire logic [OFFS_W-1:0] i_read_offset,
    input  wire logic              i_mark_saved,
    input  wire logic [ROWS_W-1:0] i_window_rows,
    output t_dp_stat               o_stat,
    output logic [CHAR_W-1:0]      o_read_char,
    output logic                   o_past_end,
    output logic [ROW_W-1:0]       o_cursor_row,
    output logic [ROW_W-1:0]       o_cursor_col,
    output logic [ROW_W-1:0]       o_top_row,
    output logic [ROW_W-1:0]       o_text_length,
    output logic                   o_modified,
    output logic [KCNT_W-1:0]      o_killed_count
);

    localparam int AW  = $clog2(TEXT_DEPTH);
    localparam int PW  = AW + 1;
    localparam int OW  = ((PW > OFFS_W) ? PW : OFFS_W) + 1;
    localparam int TW  = ((PW > ROWS_W) ? PW : ROWS_W) + 1;
    localparam int KW  = $clog2(KILL_DEPTH + 1);
    localparam int KAW = (KILL_DEPTH > 1) ? $clog2(KILL_DEPTH) : 1;

    logic [CHAR_W-1:0] r_text [TEXT_DEPTH];
    logic [CHAR_W-1:0] r_kill [KILL_DEPTH];

    logic [PW-1:0]     r_gs, n_gs, r_ge, n_ge;
    logic [PW-1:0]     r_line, n_line, r_col, n_col, r_top, n_top;
    logic [PW-1:0]     r_tgt, r_scan;
    logic [KW-1:0]     r_k, r_klen;
    logic              r_dirty;
    logic [CHAR_W-1:0] r_rdata, r_krdata, r_char, r_read_char;
    logic [OFFS_W-1:0] r_offs;
    logic              r_save, r_past_end;

    logic [PW-1:0]     gs_m1, ge_m1, scan_m1, gap, len;
    logic [OW-1:0]     offs_x, rd_k;
    logic              pe;
    logic [CHAR_W-1:0] in_norm, put_c;
    logic              put_go, put_nl, k_full, mem_we;
    logic [AW-1:0]     ra, wa;
    logic [CHAR_W-1:0] wd;
    logic [TW-1:0]     rows, top_lim;

    assign gs_m1   = r_gs - PW'(1);
    assign ge_m1   = r_ge - PW'(1);
    assign scan_m1 = r_scan - PW'(1);
    assign gap     = r_ge - r_gs;
    assign len     = PW'(TEXT_DEPTH) - gap;

    // logical offset to physical address for a read
    assign offs_x = OW'(r_offs);
    assign pe     = offs_x >= OW'(len);
    assign rd_k   = (offs_x >= OW'(r_gs)) ? offs_x + OW'(gap) : offs_x;

    // normalize the input character
    assign in_norm = (r_char == CH_CR) ? CH_NL : r_char;
    assign put_c   = i_cmd.put_src ? r_krdata : in_norm;
    assign put_go  = i_cmd.put && (r_gs != r_ge);
    assign put_nl  = put_c == CH_NL;
    assign k_full  = r_k == KW'(KILL_DEPTH);

    // window bound for downward tracking
    assign rows    = (i_window_rows == '0) ? TW'(1) : TW'(i_window_rows);
    assign top_lim = TW'(r_top) + rows;

    // gap pointers
    always_comb begin
        n_gs = r_gs;
        n_ge = r_ge;
        if (i_cmd.step_back) begin
            n_gs = gs_m1;
            n_ge = ge_m1;
        end
        if (i_cmd.step_fwd) begin
            n_gs = r_gs + PW'(1);
            n_ge = r_ge + PW'(1);
        end
        if (i_cmd.del_back) n_gs = gs_m1;
        if (i_cmd.del_fwd) n_ge = r_ge + PW'(1);
        if (put_go) n_gs = r_gs + PW'(1);
    end

    // cursor line, column and view top
    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        n_top  = r_top;
        if (i_cmd.col_clr) n_col = '0;
        if (i_cmd.col_inc) n_col = r_col + PW'(1);
        if (i_cmd.col_dec) n_col = r_col - PW'(1);
        if (i_cmd.line_inc) n_line = r_line + PW'(1);
        if (i_cmd.line_dec) n_line = r_line - PW'(1);
        if (put_go) begin
            if (put_nl) begin
                n_line = r_line + PW'(1);
                n_col  = '0;
            end else begin
                n_col = r_col + PW'(1);
            end
        end
        if (i_cmd.track_dn && (TW'(r_line) >= top_lim)) begin
            n_top = PW'(TW'(r_line) - (rows - TW'(1)));
        end
        if (i_cmd.track_up && (r_line < r_top)) n_top = r_line;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs    <= '0;
            r_ge    <= PW'(TEXT_DEPTH);
            r_line  <= '0;
            r_col   <= '0;
            r_top   <= '0;
            r_k     <= '0;
            r_klen  <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_gs   <= n_gs;
            r_ge   <= n_ge;
            r_line <= n_line;
            r_col  <= n_col;
            r_top  <= n_top;
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if ((i_cmd.kill_wr && !k_full) || i_cmd.k_inc) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.klen_load) r_klen <= r_k;
            if (i_cmd.del_back || i_cmd.del_fwd || put_go) begin
                r_dirty <= 1'b1;
            end else if (i_cmd.rd_setup && r_save) begin
                r_dirty <= 1'b0;
            end
        end
    end

    // latch item fields, walk registers and read result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_char <= i_char_in;
            r_offs <= i_read_offset;
            r_save <= i_mark_saved;
        end
        if (i_cmd.tgt_load) begin
            r_tgt <= r_col;
        end else if (i_cmd.tgt_dec) begin
            r_tgt <= r_tgt - PW'(1);
        end
        if (i_cmd.scan_load) begin
            r_scan <= n_gs;
        end else if (i_cmd.scan_dec) begin
            r_scan <= scan_m1;
        end
        if (i_cmd.res_clr || i_cmd.rd_setup) begin
            r_read_char <= '0;
            r_past_end  <= i_cmd.rd_setup && pe;
        end else if (i_cmd.char_load && !r_past_end) begin
            r_read_char <= r_rdata;
        end
    end

    // text store ports
    always_comb begin
        case (i_cmd.rsel)
            RS_GS_M1: ra = gs_m1[AW-1:0];
            RS_GE:    ra = r_ge[AW-1:0];
            RS_SCAN:  ra = scan_m1[AW-1:0];
            RS_OFFS:  ra = rd_k[AW-1:0];
            default:  ra = r_ge[AW-1:0];
        endcase
    end

    assign mem_we = i_cmd.step_back || i_cmd.step_fwd || put_go;
    assign wa     = i_cmd.step_back ? ge_m1[AW-1:0] : r_gs[AW-1:0];
    assign wd     = put_go ? put_c : r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_text[wa] <= wd;
        if (i_cmd.rd_en) r_rdata <= r_text[ra];
    end

    // kill store ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.kill_wr && !k_full) r_kill[r_k[KAW-1:0]] <= r_rdata;
        if (i_cmd.kill_rd) r_krdata <= r_kill[r_k[KAW-1:0]];
    end

    // status
    assign o_stat.gs_zero   = r_gs == '0;
    assign o_stat.ge_end    = r_ge == PW'(TEXT_DEPTH);
    assign o_stat.full      = r_gs == r_ge;
    assign o_stat.rd_nl     = r_rdata == CH_NL;
    assign o_stat.krd_nl    = r_krdata == CH_NL;
    assign o_stat.scan_zero = r_scan == '0;
    assign o_stat.line_zero = r_line == '0;
    assign o_stat.col_zero  = r_col == '0;
    assign o_stat.tgt_zero  = r_tgt == '0;
    assign o_stat.yk_done   = r_k >= r_klen;
    assign o_stat.in_nl     = (r_char == CH_NL) || (r_char == CH_CR);
    assign o_stat.in_ok     = o_stat.in_nl || ((r_char >= CH_LOW) && (r_char <= CH_HIGH));

    // result fields
    assign o_read_char    = r_read_char;
    assign o_past_end     = r_past_end;
    assign o_cursor_row   = ROW_W'(r_line);
    assign o_cursor_col   = ROW_W'(r_col);
    assign o_top_row      = ROW_W'(r_top);
    assign o_text_length  = ROW_W'(len);
    assign o_modified     = r_dirty;
    assign o_killed_count = KCNT_W'(r_klen);

    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gs <= r_ge) else $error("gap start passed gap end");
    a_kill_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_klen <= KW'(KILL_DEPTH)) else $error("kill length over depth");
    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        put_go |=> (r_gs == $past(r_gs) + PW'(1)) && (r_ge == $past(r_ge)))
        else $error("insert moved gap wrongly");

endmodule

`default_nettype wire

### sv/gbe_ctrl.sv
// Controller of the gap-buffer edit engine: sequences each command
// as reads and steps on the datapath. Uses gbe_pkg.
`default_nettype none

module gbe_ctrl
    import gbe_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire t_dp_stat         i_stat,
    output logic                  o_busy,
    output logic                  o_done,
    output t_dp_cmd               o_dp
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DISPATCH = 12'b0000_0000_0010,
        S_RD       = 12'b0000_0000_0100,
        S_EX       = 12'b0000_0000_1000,
        S_SCAN_RD  = 12'b0000_0001_0000,
        S_SCAN_EX  = 12'b0000_0010_0000,
        S_TRACK_DN = 12'b0000_0100_0000,
        S_TRACK_UP = 12'b0000_1000_0000,
        S_YK_RD    = 12'b0001_0000_0000,
        S_YK_EX    = 12'b0010_0000_0000,
        S_KFIN     = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        PH_MAIN = 3'b001,
        PH_HOME = 3'b010,
        PH_WALK = 3'b100
    } t_phase;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [CMD_W-1:0] r_cmd;
    t_rsel            rsel;
    logic             avail;

    // pick the text address for this command and phase, and whether it can be read
    always_comb begin
        case (r_cmd)
            CMD_BKSP, CMD_LEFT, CMD_LSTART: rsel = RS_GS_M1;
            CMD_UP:   rsel = (r_phase == PH_WALK) ? RS_GE : RS_GS_M1;
            CMD_READ: rsel = RS_OFFS;
            default:  rsel = RS_GE;
        endcase
        case (rsel)
            RS_GS_M1: avail = !i_stat.gs_zero;
            RS_GE:    avail = !i_stat.ge_end && ((r_phase != PH_WALK) || !i_stat.tgt_zero);
            default:  avail = 1'b1;
        endcase
    end

    // sequence the command
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_dp    = '0;
        o_dp.rsel = rsel;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_dp.load_in = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_phase = PH_MAIN;
                if (r_cmd == CMD_READ) o_dp.rd_setup = 1'b1;
                else o_dp.res_clr = 1'b1;
                case (r_cmd)
                    CMD_INSERT: begin
                        if (i_stat.in_ok && !i_stat.full) begin
                            o_dp.put = 1'b1;
                            n_state = i_stat.in_nl ? S_TRACK_DN : S_DONE;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    CMD_BKSP, CMD_LEFT, CMD_RIGHT, CMD_LEND, CMD_READ: n_state = S_RD;
                    CMD_LSTART: begin
                        o_dp.col_clr = 1'b1;
                        n_state = S_RD;
                    end
                    CMD_DOWN: begin
                        o_dp.tgt_load = 1'b1;
                        n_state = S_RD;
                    end
                    CMD_UP: begin
                        o_dp.tgt_load = 1'b1;
                        n_state = i_stat.line_zero ? S_DONE : S_RD;
                    end
                    CMD_KILL: begin
                        o_dp.k_clr = 1'b1;
                        n_state = S_RD;
                    end
                    CMD_YANK: begin
                        o_dp.k_clr = 1'b1;
                        n_state = S_YK_RD;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RD: begin
                if (avail) begin
                    o_dp.rd_en = 1'b1;
                    n_state = S_EX;
                end else if (r_cmd == CMD_KILL) begin
                    n_state = S_KFIN;
                end else if ((r_cmd == CMD_UP) && (r_phase == PH_HOME)) begin
                    o_dp.line_dec = 1'b1;
                    o_dp.col_clr  = 1'b1;
                    n_state = S_TRACK_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EX: begin
                case (r_cmd)
                    CMD_BKSP, CMD_LEFT: begin
                        if (r_cmd == CMD_BKSP) o_dp.del_back = 1'b1;
                        else o_dp.step_back = 1'b1;
                        n_state = S_DONE;
                        if (i_stat.rd_nl) begin
                            if (!i_stat.line_zero) begin
                                o_dp.line_dec  = 1'b1;
                                o_dp.col_clr   = 1'b1;
                                o_dp.scan_load = 1'b1;
                                n_state = S_SCAN_RD;
                            end
                        end else if (!i_stat.col_zero) begin
                            o_dp.col_dec = 1'b1;
                        end
                    end
                    CMD_RIGHT: begin
                        o_dp.step_fwd = 1'b1;
                        if (i_stat.rd_nl) begin
                            o_dp.line_inc = 1'b1;
                            o_dp.col_clr  = 1'b1;
                            n_state = S_TRACK_DN;
                        end else begin
                            o_dp.col_inc = 1'b1;
                            n_state = S_DONE;
                        end
                    end
                    CMD_LSTART: begin
                        if (i_stat.rd_nl) begin
                            n_state = S_DONE;
                        end else begin
                            o_dp.step_back = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    CMD_LEND: begin
                        if (i_stat.rd_nl) begin
                            n_state = S_DONE;
                        end else begin
                            o_dp.step_fwd = 1'b1;
                            o_dp.col_inc  = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    CMD_DOWN, CMD_UP: begin
                        if (r_phase == PH_WALK) begin
                            // walk toward the kept column
                            if (i_stat.rd_nl) begin
                                n_state = S_DONE;
                            end else begin
                                o_dp.step_fwd = 1'b1;
                                o_dp.col_inc  = 1'b1;
                                o_dp.tgt_dec  = 1'b1;
                                n_state = S_RD;
                            end
                        end else if (r_cmd == CMD_DOWN) begin
                            o_dp.step_fwd = 1'b1;
                            if (i_stat.rd_nl) begin
                                o_dp.line_inc = 1'b1;
                                o_dp.col_clr  = 1'b1;
                                n_phase = PH_WALK;
                                n_state = S_TRACK_DN;
                            end else begin
                                o_dp.col_inc = 1'b1;
                                n_state = S_RD;
                            end
                        end else if (r_phase == PH_HOME) begin
                            if (i_stat.rd_nl) begin
                                o_dp.line_dec = 1'b1;
                                o_dp.col_clr  = 1'b1;
                                n_state = S_TRACK_UP;
                            end else begin
                                o_dp.step_back = 1'b1;
                                n_state = S_RD;
                            end
                        end else begin
                            o_dp.step_back = 1'b1;
                            if (i_stat.rd_nl) n_phase = PH_HOME;
                            n_state = S_RD;
                        end
                    end
                    CMD_KILL: begin
                        o_dp.del_fwd = 1'b1;
                        o_dp.kill_wr = 1'b1;
                        n_state = i_stat.rd_nl ? S_KFIN : S_RD;
                    end
                    CMD_READ: begin
                        o_dp.char_load = 1'b1;
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_TRACK_DN: begin
                o_dp.track_dn = 1'b1;
                if (r_cmd == CMD_DOWN) n_state = S_RD;
                else if (r_cmd == CMD_YANK) n_state = S_YK_RD;
                else n_state = S_DONE;
            end
            S_TRACK_UP: begin
                o_dp.track_up = 1'b1;
                if (r_cmd == CMD_UP) begin
                    n_phase = PH_WALK;
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN_RD: begin
                // count back to the previous newline for the column
                if (i_stat.scan_zero) begin
                    n_state = S_TRACK_UP;
                end else begin
                    o_dp.rd_en = 1'b1;
                    o_dp.rsel  = RS_SCAN;
                    n_state = S_SCAN_EX;
                end
            end
            S_SCAN_EX: begin
                if (i_stat.rd_nl) begin
                    n_state = S_TRACK_UP;
                end else begin
                    o_dp.col_inc  = 1'b1;
                    o_dp.scan_dec = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_YK_RD: begin
                if (i_stat.yk_done) begin
                    n_state = S_DONE;
                end else begin
                    o_dp.kill_rd = 1'b1;
                    n_state = S_YK_EX;
                end
            end
            S_YK_EX: begin
                o_dp.put     = 1'b1;
                o_dp.put_src = 1'b1;
                o_dp.k_inc   = 1'b1;
                n_state = (i_stat.krd_nl && !i_stat.full) ? S_TRACK_DN : S_YK_RD;
            end
            S_KFIN: begin
                o_dp.klen_load = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_MAIN;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // hold the command for the whole item
    always_ff @(posedge i_clk) begin
        if (o_dp.load_in) r_cmd <= i_cmd;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("item accepted but not busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("busy after result");
    a_ex_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX) |-> $past(r_state == S_RD)) else $error("execute without read");

endmodule

`default_nettype wire

### sv/gap_buffer_edit_engine.sv
// Gap-buffer edit engine top level: APB window register, controller
// and datapath. Uses gbe_pkg, gbe_ctrl and gbe_dp.
// Each item passes a dispatch step, then a read and an execute step per store read
// (each character walked, killed, yanked, read or column-scanned), a view tracking
// step per line change, and a final step for a walk ending at a store edge or
// column limit, the kill length update or the yank end check, before the result.
// Busy holds through o_done; a new item is accepted only once the engine is idle.
// The receiver cannot stall; reset is synchronous, no store clearing pass.
`default_nettype none

module gap_buffer_edit_engine
    import gbe_pkg::*;
#(
    parameter int TEXT_DEPTH = DEF_TEXT_DEPTH,
    parameter int KILL_DEPTH = DEF_KILL_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [CHAR_W-1:0] i_char_in,
    input  wire logic [OFFS_W-1:0] i_read_offset,
    input  wire logic              i_mark_saved,
    output logic                   o_done,
    output logic [CHAR_W-1:0]      o_read_char,
    output logic                   o_past_end,
    output logic [ROW_W-1:0]       o_cursor_row,
    output logic [ROW_W-1:0]       o_cursor_col,
    output logic [ROW_W-1:0]       o_top_row,
    output logic [ROW_W-1:0]       o_text_length,
    output logic                   o_modified,
    output logic [KCNT_W-1:0]      o_killed_count,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [ROWS_W-1:0] r_window_rows;
    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;

    // window size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_rows <= DEF_WINDOW_ROWS;
        end else if (psel && penable && pwrite && (paddr == ADDR_WINDOW_ROWS)) begin
            r_window_rows <= pwdata[ROWS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_ROWS) ? APB_DW'(r_window_rows) : '0;

    gbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_dp    (dp_cmd)
    );

    gbe_dp #(
        .TEXT_DEPTH (TEXT_DEPTH),
        .KILL_DEPTH (KILL_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_char_in      (i_char_in),
        .i_read_offset  (i_read_offset),
        .i_mark_saved   (i_mark_saved),
        .i_window_rows  (r_window_rows),
        .o_stat         (dp_stat),
        .o_read_char    (o_read_char),
        .o_past_end     (o_past_end),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_top_row      (o_top_row),
        .o_text_length  (o_text_length),
        .o_modified     (o_modified),
        .o_killed_count (o_killed_count)
    );

endmodule

`default_nettype wire
